// ===== hdl/stereo_sad_disparity_macros.svh =====
// Assertion macros used by the stereo disparity top level.
`ifndef STEREO_SAD_DISPARITY_MACROS_SVH
`define STEREO_SAD_DISPARITY_MACROS_SVH

// Check a condition in the same cycle; uses the enclosing clk and arst_n.
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after the trigger.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ssd_pkg.sv =====
// Shared constants, types and command/status structs of the stereo disparity block.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;
	localparam int MAX_WIDTH   = 1024;
	localparam int MIN_WIDTH   = 16;
	localparam int MIN_HEIGHT  = 16;
	localparam int MAX_DISP    = 64;
	localparam int MIN_DISP    = 3;
	localparam int MAX_WINDOW  = 15;
	localparam int MIN_WINDOW  = 3;
	localparam int LINE_ROWS   = 2 * (MAX_WINDOW / 2) + 2;
	localparam int SLOT_W      = $clog2(LINE_ROWS);
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int PIX_W       = 8;
	localparam int COST_W      = 16;
	localparam logic [COST_W-1:0] COST_OUTSIDE = '1;
	localparam int PCT_SCALE   = 100;
	localparam int SCALE_NUM   = 256;
	localparam int SCALE_W     = $clog2(SCALE_NUM) + 1;
	localparam int Q_W         = 8;
	localparam int PROD_W      = 24;
	localparam int PART_W      = PIX_W + $clog2(LINE_ROWS / 2);

	localparam int W_W         = 11;
	localparam int H_W         = 12;
	localparam int DMIN_W      = 6;
	localparam int CNT_W       = 7;
	localparam int WIN_W       = 4;
	localparam int HALF_W      = 3;
	localparam int LR_W        = 6;
	localparam int PCT_W       = 8;
	localparam int DISP_W      = 8;
	localparam int IDX_W       = CNT_W;
	localparam int N_W         = DMIN_W;
	localparam int COFF_W      = WIN_W;
	localparam int XC_W        = 13;
	localparam int PIXCNT_W    = 22;
	localparam int LAG_W       = HALF_W + 1 + W_W;

	localparam int APB_AW      = 5;
	localparam int APB_DW      = 32;
	localparam int S_DATA_W    = 2 * PIX_W;
	localparam int M_DATA_W    = DISP_W;

	typedef struct packed {
		logic [W_W-1:0]    width;
		logic [H_W-1:0]    height;
		logic [DMIN_W-1:0] dmin;
		logic [CNT_W-1:0]  count;
		logic [HALF_W-1:0] half;
		logic [LR_W-1:0]   lr;
		logic [PCT_W-1:0]  pct;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [H_W-1:0]   y;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [COL_W-1:0]  col;
		logic [PIX_W-1:0]  lpix;
		logic [PIX_W-1:0]  rpix;
	} wr_t;

	typedef struct packed {
		logic init;
		logic cost_start;
		logic issue;
		logic rev;
		logic fwd_upd;
		logic rev_init;
		logic rev_upd;
		logic rev_skip;
		logic check;
	} cmd_t;

	typedef struct packed {
		logic border;
		logic fwd_done;
		logic rev_done;
		logic outside;
		logic col_last;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

// ===== hdl/ssd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ssd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== hdl/ssd_ctrl.sv =====
// Sequencer for the forward search, reverse check and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module ssd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          out_free,
	input  ssd_pkg::sts_t sts,
	output ssd_pkg::cmd_t cmd,
	output logic          idle,
	output logic          load
);
	import ssd_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_SETUP    = 10'b0000000010,
		ST_ISSUE    = 10'b0000000100,
		ST_WAIT1    = 10'b0000001000,
		ST_WAIT2    = 10'b0000010000,
		ST_UPDATE   = 10'b0000100000,
		ST_REV_INIT = 10'b0001000000,
		ST_CHECK    = 10'b0010000000,
		ST_RESULT   = 10'b0100000000,
		ST_SPARE    = 10'b1000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   rev_q, rev_nxt;

	always_comb begin
		state_nxt = state_q;
		rev_nxt   = rev_q;
		cmd       = '0;
		cmd.rev   = rev_q;
		idle      = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					cmd.init  = 1'b1;
					rev_nxt   = 1'b0;
					state_nxt = sts.border ? ST_CHECK : ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (!rev_q) begin
					if (sts.fwd_done) begin
						state_nxt = ST_REV_INIT;
					end else begin
						cmd.cost_start = 1'b1;
						state_nxt      = ST_ISSUE;
					end
				end else if (sts.rev_done) begin
					state_nxt = ST_CHECK;
				end else if (sts.outside) begin
					cmd.rev_skip = 1'b1;
				end else begin
					cmd.cost_start = 1'b1;
					state_nxt      = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.col_last) begin
					state_nxt = ST_WAIT1;
				end
			end
			ST_WAIT1: begin
				state_nxt = ST_WAIT2;
			end
			ST_WAIT2: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.fwd_upd = !rev_q;
				cmd.rev_upd = rev_q;
				state_nxt   = ST_SETUP;
			end
			ST_REV_INIT: begin
				cmd.rev_init = 1'b1;
				rev_nxt      = 1'b1;
				state_nxt    = ST_SETUP;
			end
			ST_CHECK: begin
				if (sts.div_done || sts.border) begin
					cmd.check = 1'b1;
					state_nxt = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					load      = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rev_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rev_q   <= rev_nxt;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/ssd_dp.sv =====
// Line-store RAMs, column SAD unit, cost accumulator, minimum tracking and result math.
`timescale 1ns / 1ps
`default_nettype none
module ssd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssd_pkg::cfg_t               cfg,
	input  ssd_pkg::job_t               job,
	input  ssd_pkg::wr_t                wr,
	input  ssd_pkg::cmd_t               cmd,
	output ssd_pkg::sts_t               sts,
	output logic [ssd_pkg::DISP_W-1:0]  disp
);
	import ssd_pkg::*;

	logic [IDX_W-1:0]   d_q;
	logic [COFF_W-1:0]  c_q;
	logic [COST_W-1:0]  acc_q, best_q, t_q, u1_q, u2_q;
	logic [N_W-1:0]     n_q;
	logic [IDX_W-1:0]   d1_q;
	logic [SCALE_W-1:0] rem_q;
	logic [Q_W-1:0]     q_q;
	logic               lr_ok_q;
	logic [PROD_W-1:0]  lhs_q, rhs_q;
	logic [DISP_W-1:0]  scaled_q;

	logic               valid_s1, lz_s1, rz_s1;
	logic               valid_s2;
	logic [PART_W-1:0]  part0_s2, part1_s2;

	logic [XC_W-1:0]    x_ext, y_ext, n_ext, d_ext, half_ext, half1, w_ext, h_ext;
	logic [XC_W-1:0]    xc, rcol, lcol;
	logic               lz, rz;
	logic [SLOT_W-1:0]  base, span;
	logic [LINE_ROWS-1:0] sel;
	logic [PIX_W-1:0]   ldat_s1 [LINE_ROWS];
	logic [PIX_W-1:0]   rdat_s1 [LINE_ROWS];
	logic [PIX_W-1:0]   absd [LINE_ROWS];
	logic [PIX_W-1:0]   a_v [LINE_ROWS];
	logic [PIX_W-1:0]   b_v [LINE_ROWS];
	logic [PART_W-1:0]  part0_c, part1_c;
	logic [IDX_W-1:0]   lr_diff;

	assign x_ext    = XC_W'(job.x);
	assign y_ext    = XC_W'(job.y);
	assign n_ext    = XC_W'(n_q);
	assign d_ext    = XC_W'(d_q);
	assign half_ext = XC_W'(cfg.half);
	assign half1    = half_ext + XC_W'(1);
	assign w_ext    = XC_W'(cfg.width);
	assign h_ext    = XC_W'(cfg.height);

	// forward search is centered on x, the reverse check slides by n - d
	assign xc   = cmd.rev ? (x_ext + n_ext - d_ext) : x_ext;
	assign rcol = xc + XC_W'(c_q) - half_ext;
	assign lcol = rcol + XC_W'(cfg.dmin) + d_ext;
	assign lz   = ($signed(lcol) < 0) || ($signed(lcol) >= $signed(w_ext));
	assign rz   = ($signed(rcol) < 0) || ($signed(rcol) >= $signed(w_ext));

	assign sts.border   = (y_ext < half1) || (y_ext + half1 >= h_ext)
		|| (x_ext < half1) || (x_ext + half1 >= w_ext);
	assign sts.fwd_done = (d_q + IDX_W'(1)) >= cfg.count;
	assign sts.rev_done = d_q >= cfg.count;
	assign sts.outside  = ($signed(xc) < $signed(half1))
		|| ($signed(xc) >= $signed(w_ext - half_ext));
	assign sts.col_last = c_q == COFF_W'({cfg.half, 1'b0});
	assign sts.div_done = rem_q < SCALE_W'(cfg.count);

	genvar g;
	for (g = 0; g < LINE_ROWS; g++) begin : g_row
		logic row_we;
		assign row_we = wr.en && (wr.slot == SLOT_W'(g));
		ssd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_left (
			.clk   (clk),
			.we    (row_we),
			.waddr (wr.col),
			.wdata (wr.lpix),
			.raddr (lcol[COL_W-1:0]),
			.rdata (ldat_s1[g])
		);
		ssd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_right (
			.clk   (clk),
			.we    (row_we),
			.waddr (wr.col),
			.wdata (wr.rpix),
			.raddr (rcol[COL_W-1:0]),
			.rdata (rdat_s1[g])
		);
	end

	// window rows y-half .. y+half map onto a contiguous run of line slots
	assign base = job.y[SLOT_W-1:0] - SLOT_W'(cfg.half);
	assign span = SLOT_W'({cfg.half, 1'b0});

	always_comb begin
		for (int s = 0; s < LINE_ROWS; s++) begin
			sel[s]  = (SLOT_W'(s) - base) <= span;
			a_v[s]  = lz_s1 ? '0 : ldat_s1[s];
			b_v[s]  = rz_s1 ? '0 : rdat_s1[s];
			absd[s] = !sel[s] ? '0 : (a_v[s] > b_v[s]) ? a_v[s] - b_v[s] : b_v[s] - a_v[s];
		end
		part0_c = '0;
		part1_c = '0;
		for (int i = 0; i < LINE_ROWS / 2; i++) begin
			part0_c = part0_c + PART_W'(absd[i]);
			part1_c = part1_c + PART_W'(absd[i + LINE_ROWS / 2]);
		end
	end

	assign lr_diff = (d1_q >= IDX_W'(n_q)) ? d1_q - IDX_W'(n_q) : IDX_W'(n_q) - d1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		lz_s1    <= lz;
		rz_s1    <= rz;
		part0_s2 <= part0_c;
		part1_s2 <= part1_c;

		if (cmd.cost_start) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + COST_W'(part0_s2) + COST_W'(part1_s2);
		end

		if (cmd.cost_start) begin
			c_q <= '0;
		end else if (cmd.issue) begin
			c_q <= c_q + COFF_W'(1);
		end

		if (cmd.init) begin
			d_q <= IDX_W'(1);
		end else if (cmd.rev_init) begin
			d_q <= '0;
		end else if (cmd.fwd_upd || cmd.rev_upd || cmd.rev_skip) begin
			d_q <= d_q + IDX_W'(1);
		end

		if (cmd.init) begin
			best_q <= COST_OUTSIDE;
			n_q    <= '0;
		end else if (cmd.fwd_upd && (best_q > acc_q)) begin
			best_q <= acc_q;
			n_q    <= d_q[N_W-1:0];
		end

		// keep the costs displaced by the two latest new minima; the margin test uses the earlier one
		if (cmd.rev_init) begin
			t_q  <= COST_OUTSIDE;
			u1_q <= COST_OUTSIDE;
			u2_q <= COST_OUTSIDE;
			d1_q <= '0;
		end else if (cmd.rev_upd && (t_q > acc_q)) begin
			u2_q <= u1_q;
			u1_q <= t_q;
			t_q  <= acc_q;
			d1_q <= d_q;
		end

		// 256 / count by repeated subtraction while the search runs
		if (cmd.init) begin
			rem_q <= SCALE_W'(SCALE_NUM);
			q_q   <= '0;
		end else if (!sts.div_done) begin
			rem_q <= rem_q - SCALE_W'(cfg.count);
			q_q   <= q_q + Q_W'(1);
		end

		if (cmd.check) begin
			lr_ok_q  <= lr_diff <= IDX_W'(cfg.lr);
			lhs_q    <= PROD_W'(u2_q - t_q) * PROD_W'(PCT_SCALE);
			rhs_q    <= PROD_W'(t_q) * PROD_W'(cfg.pct);
			scaled_q <= DISP_W'(PROD_W'(n_q) * PROD_W'(q_q));
		end
	end

	assign disp = sts.border ? '0 : (lr_ok_q && (lhs_q >= rhs_q)) ? scaled_q : '0;
endmodule
`default_nettype wire

// ===== hdl/stereo_sad_disparity.sv =====
// Stereo SAD block matcher with left-right and uniqueness checks, one disparity per pixel.
// A beat that yields no result does not hold the input. An interior result runs the
// forward search and the reverse check (a reverse cost off the matched band is skipped)
// and waits for the 256/count division; a border result skips the search and division.
// The single column SAD unit reads one window column per cycle from 16 row RAMs per image.
// Reset: config to defaults, frame counters zero; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module stereo_sad_disparity (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssd_pkg::APB_AW-1:0]    paddr,
	input  logic [ssd_pkg::APB_DW-1:0]    pwdata,
	output logic [ssd_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	// pixel input
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ssd_pkg::S_DATA_W-1:0]  s_tdata,  // left_pixel [7:0], right_pixel [15:8]
	input  logic [0:0]                    s_tuser,  // action [0]
	// disparity output
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ssd_pkg::M_DATA_W-1:0]  m_tdata,  // disparity_value [7:0]
	output logic                          m_tlast
);
	`include "stereo_sad_disparity_macros.svh"
	import ssd_pkg::*;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_DMIN   = 3'd2,
		REG_COUNT  = 3'd3,
		REG_WINDOW = 3'd4,
		REG_LR     = 3'd5,
		REG_PCT    = 3'd6
	} reg_idx_t;

	// raw configuration registers
	logic [W_W-1:0]    width_q;
	logic [H_W-1:0]    height_q;
	logic [DMIN_W-1:0] dmin_q;
	logic [CNT_W-1:0]  count_q;
	logic [WIN_W-1:0]  window_q;
	logic [LR_W-1:0]   lr_q;
	logic [PCT_W-1:0]  pct_q;

	cfg_t     eff;
	reg_idx_t reg_idx;
	logic     cfg_wr, cfg_hit;

	// frame position of the input and output streams
	logic [COL_W-1:0]    col_q, ox_q;
	logic [H_W-1:0]      row_q, oy_q;
	logic [PIXCNT_W-1:0] in_cnt_q, out_k_q, total;
	logic [LAG_W-1:0]    lag;

	job_t  job_q;
	logic  job_last_q;
	logic  start_q;
	logic  out_valid_q, out_last_q;
	logic [DISP_W-1:0] out_data_q;

	logic  accept, draining, action, pix_in, emit, emit_last, restart;
	logic  col_wrap, ox_wrap;
	logic  eng_idle, out_load, out_free;
	wr_t   wr;
	cmd_t  cmd;
	sts_t  sts;
	logic [DISP_W-1:0] disp;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	// a write to any listed register restarts the frame
	assign cfg_hit = cfg_wr && (paddr[APB_AW-1:2] <= 3'(REG_PCT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_W'(640);
			height_q <= H_W'(480);
			dmin_q   <= '0;
			count_q  <= CNT_W'(MAX_DISP);
			window_q <= WIN_W'(9);
			lr_q     <= LR_W'(1);
			pct_q    <= PCT_W'(15);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[W_W-1:0];
				REG_HEIGHT: height_q <= pwdata[H_W-1:0];
				REG_DMIN:   dmin_q   <= pwdata[DMIN_W-1:0];
				REG_COUNT:  count_q  <= pwdata[CNT_W-1:0];
				REG_WINDOW: window_q <= pwdata[WIN_W-1:0];
				REG_LR:     lr_q     <= pwdata[LR_W-1:0];
				REG_PCT:    pct_q    <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_DMIN:   prdata = APB_DW'(dmin_q);
			REG_COUNT:  prdata = APB_DW'(count_q);
			REG_WINDOW: prdata = APB_DW'(window_q);
			REG_LR:     prdata = APB_DW'(lr_q);
			REG_PCT:    prdata = APB_DW'(pct_q);
			default:    prdata = '0;
		endcase
	end

	// clamp width, height, count and window into their working ranges; an even window acts as the next odd
	always_comb begin
		eff.width  = (width_q < W_W'(MIN_WIDTH)) ? W_W'(MIN_WIDTH)
			: (width_q > W_W'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : width_q;
		eff.height = (height_q < H_W'(MIN_HEIGHT)) ? H_W'(MIN_HEIGHT) : height_q;
		eff.dmin   = dmin_q;
		eff.count  = (count_q < CNT_W'(MIN_DISP)) ? CNT_W'(MIN_DISP)
			: (count_q > CNT_W'(MAX_DISP)) ? CNT_W'(MAX_DISP) : count_q;
		eff.half   = (window_q < WIN_W'(MIN_WINDOW)) ? HALF_W'(MIN_WINDOW / 2)
			: window_q[WIN_W-1:1];
		eff.lr     = lr_q;
		eff.pct    = pct_q;
	end

	// results trail the input by half+1 rows; the frame holds height*width results
	assign lag   = LAG_W'(LAG_W'(eff.half) + LAG_W'(1)) * LAG_W'(eff.width);
	assign total = PIXCNT_W'(eff.height) * PIXCNT_W'(eff.width);

	// the engine works one result at a time; hold input while it is busy
	assign s_tready  = eng_idle && !start_q;
	assign accept    = s_tvalid && s_tready;
	assign action    = s_tuser[0];
	assign draining  = row_q >= eff.height;
	assign pix_in    = accept && !draining && !action;
	// once the frame input is complete, every beat drains one result
	assign emit      = accept && (draining
		|| (!action && (in_cnt_q >= PIXCNT_W'(lag))));
	assign emit_last = (out_k_q + PIXCNT_W'(1)) >= total;
	assign restart   = cfg_hit || (emit && emit_last);
	assign col_wrap  = (W_W'(col_q) + W_W'(1)) >= eff.width;
	assign ox_wrap   = (W_W'(ox_q) + W_W'(1)) >= eff.width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			in_cnt_q <= '0;
			out_k_q  <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
		end else if (restart) begin
			col_q    <= '0;
			row_q    <= '0;
			in_cnt_q <= '0;
			out_k_q  <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
		end else begin
			if (pix_in) begin
				in_cnt_q <= in_cnt_q + PIXCNT_W'(1);
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + H_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (emit) begin
				out_k_q <= out_k_q + PIXCNT_W'(1);
				if (ox_wrap) begin
					ox_q <= '0;
					oy_q <= oy_q + H_W'(1);
				end else begin
					ox_q <= ox_q + COL_W'(1);
				end
			end
		end
	end

	// latch the output position for the engine; it stays put until the engine is idle again
	always_ff @(posedge clk) begin
		if (emit) begin
			job_q.x    <= ox_q;
			job_q.y    <= oy_q;
			job_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= emit;
		end
	end

	// write the pixel pair into the line slot of its row
	assign wr.en   = pix_in;
	assign wr.slot = row_q[SLOT_W-1:0];
	assign wr.col  = col_q;
	assign wr.lpix = s_tdata[PIX_W-1:0];
	assign wr.rpix = s_tdata[2*PIX_W-1:PIX_W];

	// output register parts the engine from the downstream stall
	assign out_free = !out_valid_q || m_tready;

	ssd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (eng_idle),
		.load     (out_load)
	);

	ssd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (eff),
		.job    (job_q),
		.wr     (wr),
		.cmd    (cmd),
		.sts    (sts),
		.disp   (disp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= disp;
			out_last_q <= job_last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`SSD_ASSERT_SAME(a_load_free, out_load, !m_tvalid || m_tready, "result overwrote a waiting beat")
	`SSD_ASSERT_SAME(a_wr_idle, wr.en, eng_idle, "line store written while engine busy")
	`SSD_ASSERT_NEXT(a_start_busy, start_q, !eng_idle, "engine did not take its start")
	`SSD_ASSERT_NEXT(a_frame_wrap, emit && emit_last, out_k_q == '0 && row_q == '0, "frame did not restart")
endmodule
`default_nettype wire
